/* hdl/masked_window_sum_sqsum_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the masked window sum unit
// Short concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef MASKED_WINDOW_SUM_SQSUM_UNIT_DEFINES_SVH
`define MASKED_WINDOW_SUM_SQSUM_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mws_pkg.sv */
// ---------------------------------------------------------------------------
// mws_pkg
// Types, constants and helpers shared by the masked window sum unit.
// ---------------------------------------------------------------------------
package mws_pkg;

  localparam int unsigned MaxImageWidthDef    = 1024;
  localparam int unsigned MaxTemplateHeightDef = 64;
  localparam int unsigned MaxTemplateWidthDef = 64;
  localparam int unsigned MaxRunsDef          = 256;

  localparam int unsigned SumW  = 18;
  localparam int unsigned SqW   = 27;
  localparam int unsigned OSumW = 20;
  localparam int unsigned OSqW  = 28;

  typedef enum logic [2:0] {
    CfgImageWidth    = 3'd0,
    CfgImageHeight   = 3'd1,
    CfgTemplateWidth = 3'd2,
    CfgTemplateHeight = 3'd3,
    CfgRunCount      = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CmdRunWrite = 1'b0,
    CmdPixel    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] run_index;
    logic [5:0] run_row;
    logic [5:0] run_col;
    logic [6:0] run_length;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  window_x;
    logic [11:0] window_y;
    logic [19:0] window_sum;
    logic [27:0] window_square_sum;
  } out_item_t;

  // window job handed from front to back
  typedef struct packed {
    logic [11:0] x0;
    logic [11:0] y0;
  } job_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic [6:0] len;
  } run_t;

endpackage

/* hdl/mws_ram.sv */
// ---------------------------------------------------------------------------
// mws_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module mws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/mws_front.sv */
// ---------------------------------------------------------------------------
// mws_front
// Takes items: writes run entries, streams pixels into the prefix stores
// and posts a window job when a pixel closes a window.
// ---------------------------------------------------------------------------
module mws_front #(
  parameter int unsigned MaxImageWidth    = mws_pkg::MaxImageWidthDef,
  parameter int unsigned MaxTemplateHeight = mws_pkg::MaxTemplateHeightDef,
  parameter int unsigned MaxTemplateWidth = mws_pkg::MaxTemplateWidthDef,
  parameter int unsigned MaxRuns          = mws_pkg::MaxRunsDef,
  localparam int unsigned ColW = $clog2(MaxImageWidth),
  localparam int unsigned RowSelW = (MaxTemplateHeight > 1) ? $clog2(MaxTemplateHeight) : 1,
  localparam int unsigned AddrW = $clog2(MaxImageWidth * MaxTemplateHeight),
  localparam int unsigned RunAW = (MaxRuns > 1) ? $clog2(MaxRuns) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mws_pkg::in_item_t  in_data_i,
  input  logic [10:0]        image_width_i,
  input  logic [12:0]        image_height_i,
  input  logic [6:0]         template_width_i,
  input  logic [6:0]         template_height_i,
  input  logic               job_full_i,
  output logic               job_push_o,
  output mws_pkg::job_t      job_o,
  output logic               run_we_o,
  output logic [RunAW-1:0]   run_waddr_o,
  output mws_pkg::run_t      run_wdata_o,
  output logic               st_we_o,
  output logic [AddrW-1:0]   st_waddr_o,
  output logic [mws_pkg::SumW-1:0] st_sum_o,
  output logic [mws_pkg::SqW-1:0]  st_sq_o
);
  import mws_pkg::*;

  logic [11:0]     col_q, col_d, row_q, row_d;
  logic [SumW-1:0] rsum_q, rsum_d;
  logic [SqW-1:0]  rsq_q, rsq_d;
  logic [12:0]     w, h;
  logic [8:0]      tw, th;
  logic [11:0]     col, row;
  logic [15:0]     psq;
  logic            is_pix, fire, done;
  logic [12:0]     c1, r1;

  always_comb begin
    w = (image_width_i == '0) ? 13'd1 :
        ({2'b0, image_width_i} > 13'(MaxImageWidth)) ? 13'(MaxImageWidth) :
        {2'b0, image_width_i};
    h = (image_height_i == '0) ? 13'd1 : image_height_i;
    tw = (template_width_i == '0) ? 9'd1 :
         ({2'b0, template_width_i} > 9'(MaxTemplateWidth)) ? 9'(MaxTemplateWidth) :
         {2'b0, template_width_i};
    th = (template_height_i == '0) ? 9'd1 :
         ({2'b0, template_height_i} > 9'(MaxTemplateHeight)) ? 9'(MaxTemplateHeight) :
         {2'b0, template_height_i};
    col = col_q;
    row = row_q;
    if ({1'b0, col} >= w) begin
      col = '0;
      row = row_q + 12'd1;
    end
    if ({1'b0, row} >= h) row = '0;
    c1 = {1'b0, col} + 13'd1;
    r1 = {1'b0, row} + 13'd1;
  end

  assign is_pix = in_data_i.command == CmdPixel;
  assign done = c1 >= {4'b0, tw} && r1 >= {4'b0, th};
  // hold items while a window job waits or is being walked
  assign in_ready_o = !job_full_i;
  assign fire = in_valid_i && in_ready_o && is_pix;
  assign psq = in_data_i.pixel * in_data_i.pixel;

  always_comb begin
    if (col == '0) begin
      rsum_d = SumW'(in_data_i.pixel);
      rsq_d  = SqW'(psq);
    end else begin
      rsum_d = rsum_q + SumW'(in_data_i.pixel);
      rsq_d  = rsq_q + SqW'(psq);
    end
    col_d = col;
    row_d = row;
    if (c1 >= w) begin
      col_d = '0;
      row_d = (r1 >= h) ? 12'd0 : r1[11:0];
    end else begin
      col_d = c1[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rsum_q <= '0;
      rsq_q  <= '0;
    end else if (fire) begin
      col_q  <= col_d;
      row_q  <= row_d;
      rsum_q <= rsum_d;
      rsq_q  <= rsq_d;
    end
  end

  assign st_we_o    = fire;
  assign st_waddr_o = AddrW'({row[RowSelW-1:0], col[ColW-1:0]});
  assign st_sum_o   = rsum_d;
  assign st_sq_o    = rsq_d;

  assign job_push_o = fire && done;
  assign job_o.x0   = 12'(c1 - {4'b0, tw});
  assign job_o.y0   = 12'(r1 - {4'b0, th});

  assign run_we_o    = in_valid_i && in_ready_o && !is_pix &&
                       ({24'b0, in_data_i.run_index} < 32'(MaxRuns));
  assign run_waddr_o = RunAW'(in_data_i.run_index);
  assign run_wdata_o = '{row: in_data_i.run_row, col: in_data_i.run_col,
                         len: in_data_i.run_length};
endmodule

/* hdl/mws_queue.sv */
// ---------------------------------------------------------------------------
// mws_queue
// Two-entry job queue between front and back.
// ---------------------------------------------------------------------------
module mws_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mws_pkg::job_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mws_pkg::job_t data_o
);
  import mws_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

/* hdl/mws_back.sv */
// ---------------------------------------------------------------------------
// mws_back
// Walks the run table for one window job: two prefix reads per run inside the
// template, accumulate, saturate and present the result.
// ---------------------------------------------------------------------------
module mws_back #(
  parameter int unsigned MaxImageWidth    = mws_pkg::MaxImageWidthDef,
  parameter int unsigned MaxTemplateHeight = mws_pkg::MaxTemplateHeightDef,
  parameter int unsigned MaxTemplateWidth = mws_pkg::MaxTemplateWidthDef,
  parameter int unsigned MaxRuns          = mws_pkg::MaxRunsDef,
  localparam int unsigned ColW = $clog2(MaxImageWidth),
  localparam int unsigned RowSelW = (MaxTemplateHeight > 1) ? $clog2(MaxTemplateHeight) : 1,
  localparam int unsigned AddrW = $clog2(MaxImageWidth * MaxTemplateHeight),
  localparam int unsigned RunAW = (MaxRuns > 1) ? $clog2(MaxRuns) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [6:0]         template_width_i,
  input  logic [6:0]         template_height_i,
  input  logic [8:0]         run_count_i,
  input  logic               job_valid_i,
  input  mws_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic [RunAW-1:0]   run_raddr_o,
  input  mws_pkg::run_t      run_rdata_i,
  output logic [AddrW-1:0]   st_raddr_o,
  input  logic [mws_pkg::SumW-1:0] st_sum_i,
  input  logic [mws_pkg::SqW-1:0]  st_sq_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mws_pkg::out_item_t out_data_o,
  output logic               busy_o
);
  import mws_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StRun   = 6'b000010,
    StHi    = 6'b000100,
    StLo    = 6'b001000,
    StAcc   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  state_e          st_q, st_d;
  job_t            job_q;
  logic [12:0]     k_q, k_d, n;
  logic [26:0]     s_q, s_d;
  logic [35:0]     q_q, q_d;
  logic            has_lo_q;
  logic [SumW-1:0] hs_q;
  logic [SqW-1:0]  hq_q;
  logic [8:0]      tw, th, endc;
  logic [12:0]     a, b, ry;
  logic            skip;
  logic [AddrW-1:0] addr_a, addr_b;

  assign tw = (template_width_i == '0) ? 9'd1 :
              ({2'b0, template_width_i} > 9'(MaxTemplateWidth)) ? 9'(MaxTemplateWidth) :
              {2'b0, template_width_i};
  assign th = (template_height_i == '0) ? 9'd1 :
              ({2'b0, template_height_i} > 9'(MaxTemplateHeight)) ? 9'(MaxTemplateHeight) :
              {2'b0, template_height_i};
  assign n = ({4'b0, run_count_i} > 13'(MaxRuns)) ? 13'(MaxRuns) : {4'b0, run_count_i};

  always_comb begin
    skip = ({3'b0, run_rdata_i.row} >= th) || ({3'b0, run_rdata_i.col} >= tw) ||
           (run_rdata_i.len == '0);
    endc = {3'b0, run_rdata_i.col} + {2'b0, run_rdata_i.len};
    if (endc > tw) endc = tw;
    a  = {1'b0, job_q.x0} + {7'b0, run_rdata_i.col};
    b  = {1'b0, job_q.x0} + {4'b0, endc} - 13'd1;
    ry = {1'b0, job_q.y0} + {7'b0, run_rdata_i.row};
    addr_b = AddrW'({ry[RowSelW-1:0], b[ColW-1:0]});
    addr_a = AddrW'({ry[RowSelW-1:0], ColW'(a - 13'd1)});
  end

  assign run_raddr_o = RunAW'(k_q);
  assign st_raddr_o  = (st_q == StHi) ? addr_b : addr_a;
  assign busy_o      = st_q != StIdle || job_valid_i;
  assign out_valid_o = st_q == StOut;
  assign job_pop_o   = st_q == StIdle && job_valid_i;

  always_comb begin
    st_d = st_q;
    k_d  = k_q;
    s_d  = s_q;
    q_d  = q_q;
    case (st_q)
      StIdle: begin
        if (job_valid_i) begin
          st_d = StRun;
          k_d = '0;
          s_d = '0;
          q_d = '0;
        end
      end
      StRun: begin
        // run entry address k_q is issued now; its data is valid in StHi
        if (k_q >= n) st_d = StOut;
        else st_d = StHi;
      end
      StHi: begin
        // run data valid now; issue the high prefix read, the low one follows
        if (skip) begin
          k_d = k_q + 13'd1;
          st_d = StRun;
        end else begin
          st_d = StLo;
        end
      end
      StLo: st_d = StAcc;
      StAcc: begin
        k_d = k_q + 13'd1;
        st_d = StRun;
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // hold the high prefix, then accumulate the difference
  logic [SumW-1:0] ds;
  logic [SqW-1:0]  dq;
  assign ds = has_lo_q ? hs_q - st_sum_i : hs_q;
  assign dq = has_lo_q ? hq_q - st_sq_i : hq_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (st_q == StHi) has_lo_q <= a != '0;
    if (st_q == StLo) begin
      hs_q <= st_sum_i;
      hq_q <= st_sq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      k_q  <= '0;
      s_q  <= '0;
      q_q  <= '0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      if (st_q == StAcc) begin
        s_q <= s_q + 27'(ds);
        q_q <= q_q + 36'(dq);
      end else begin
        s_q <= s_d;
        q_q <= q_d;
      end
    end
  end

  assign out_data_o.window_x = job_q.x0[9:0];
  assign out_data_o.window_y = job_q.y0;
  assign out_data_o.window_sum = (s_q > 27'(20'hFFFFF)) ? 20'hFFFFF : s_q[19:0];
  assign out_data_o.window_square_sum = (q_q > 36'(28'hFFFFFFF)) ? 28'hFFFFFFF : q_q[27:0];
endmodule

/* hdl/masked_window_sum_sqsum_unit.sv */
// Flow: a window job goes from StIdle through StRun, StHi, StLo and StAcc for each run,
// then StOut; a run outside the box returns from StHi to StRun with no prefix reads.
// Throughput: one pixel or run write per cycle until a pixel closes a window; the
// next item then waits until that result is taken.
// Reset clears counters, running sums and control; stores stay undefined.
// ---------------------------------------------------------------------------
// masked_window_sum_sqsum_unit
// Masked sliding-window sum and square sum over a streamed 8-bit image.
// ---------------------------------------------------------------------------
`include "masked_window_sum_sqsum_unit_defines.svh"
module masked_window_sum_sqsum_unit #(
  parameter int unsigned MaxImageWidth    = mws_pkg::MaxImageWidthDef,
  parameter int unsigned MaxTemplateHeight = mws_pkg::MaxTemplateHeightDef,
  parameter int unsigned MaxTemplateWidth = mws_pkg::MaxTemplateWidthDef,
  parameter int unsigned MaxRuns          = mws_pkg::MaxRunsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mws_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mws_pkg::out_item_t out_data_o
);
  import mws_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxImageWidth * MaxTemplateHeight);
  localparam int unsigned RunAW = (MaxRuns > 1) ? $clog2(MaxRuns) : 1;

  logic [10:0] iw_q;
  logic [12:0] ih_q;
  logic [6:0]  tw_q, th_q;
  logic [8:0]  rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= 11'd640;
      ih_q <= 13'd480;
      tw_q <= 7'd16;
      th_q <= 7'd16;
      rc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:     iw_q <= cfg_data_i[10:0];
        CfgImageHeight:    ih_q <= cfg_data_i;
        CfgTemplateWidth:  tw_q <= cfg_data_i[6:0];
        CfgTemplateHeight: th_q <= cfg_data_i[6:0];
        CfgRunCount:       rc_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic             job_full, job_push, job_valid, job_pop, busy;
  job_t             job_in, job_out;
  logic             run_we;
  logic [RunAW-1:0] run_waddr, run_raddr;
  run_t             run_wdata, run_rdata;
  logic             st_we;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [SumW-1:0]  st_wsum, st_rsum;
  logic [SqW-1:0]   st_wsq, st_rsq;

  // hold input while a window is walked so the stores and the run table stay put
  mws_front #(
    .MaxImageWidth(MaxImageWidth), .MaxTemplateHeight(MaxTemplateHeight),
    .MaxTemplateWidth(MaxTemplateWidth), .MaxRuns(MaxRuns)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .image_width_i(iw_q), .image_height_i(ih_q),
    .template_width_i(tw_q), .template_height_i(th_q),
    .job_full_i(job_full || busy), .job_push_o(job_push), .job_o(job_in),
    .run_we_o(run_we), .run_waddr_o(run_waddr), .run_wdata_o(run_wdata),
    .st_we_o(st_we), .st_waddr_o(st_waddr), .st_sum_o(st_wsum), .st_sq_o(st_wsq)
  );

  mws_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .valid_o(job_valid), .pop_i(job_pop), .data_o(job_out)
  );

  mws_ram #(.Width($bits(run_t)), .Depth(2 ** RunAW)) u_run_ram (
    .clk_i, .we_i(run_we), .waddr_i(run_waddr), .wdata_i(run_wdata),
    .raddr_i(run_raddr), .rdata_o(run_rdata)
  );

  mws_ram #(.Width(SumW), .Depth(2 ** AddrW)) u_sum_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wsum),
    .raddr_i(st_raddr), .rdata_o(st_rsum)
  );

  mws_ram #(.Width(SqW), .Depth(2 ** AddrW)) u_sq_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wsq),
    .raddr_i(st_raddr), .rdata_o(st_rsq)
  );

  mws_back #(
    .MaxImageWidth(MaxImageWidth), .MaxTemplateHeight(MaxTemplateHeight),
    .MaxTemplateWidth(MaxTemplateWidth), .MaxRuns(MaxRuns)
  ) u_back (
    .clk_i, .rst_ni, .template_width_i(tw_q), .template_height_i(th_q),
    .run_count_i(rc_q), .job_valid_i(job_valid), .job_i(job_out),
    .job_pop_o(job_pop), .run_raddr_o(run_raddr), .run_rdata_i(run_rdata),
    .st_raddr_o(st_raddr), .st_sum_i(st_rsum), .st_sq_i(st_rsq),
    .out_valid_o, .out_ready_i, .out_data_o, .busy_o(busy)
  );

  `MWS_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, job_full, !job_push,
    "job pushed into full queue")
  `MWS_ASSERT_IMP(a_pop_valid, clk_i, rst_ni, job_pop, job_valid,
    "job popped from empty queue")
  `MWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "result dropped while stalled")
  `MWS_ASSERT_IMP(a_out_busy, clk_i, rst_ni, out_valid_o, busy,
    "result shown while back end idle")
endmodule
